// ===== hw/rtl/sle_pkg.sv =====
// Shared types, codes and helpers for the sprite line evaluator.
package sle_pkg;

    // Default sizing
    localparam int SPRITES_PER_LINE_DEF = 8;
    localparam int TABLE_ENTRIES_DEF    = 64;

    // Line latched for any negative (pre-render) line number
    localparam logic [8:0] PRE_RENDER_LINE = 9'h1FF;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_FETCH   = 2'd2,
        KIND_PATTERN = 2'd3
    } t_kind;

    // Result kinds
    localparam logic RES_ADDR    = 1'b0;
    localparam logic RES_PATTERN = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TALL      = 2'd0;
    localparam logic [1:0] CFG_TABLE_SEL = 2'd1;

    // Attribute flag bits
    localparam int FLAG_VFLIP = 7;
    localparam int FLAG_HFLIP = 6;

    // Kept sprite entry
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] tile;
        logic [7:0] flags;
    } t_entry;

    // Row unit answer
    typedef struct packed {
        logic        qualify;
        logic [12:0] addr_low;
    } t_row_res;

    // Bit reversal of one pattern byte
    function automatic logic [7:0] mirror_bits(input logic [7:0] v);
        logic [7:0] a;
        logic [7:0] b;
        a = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((a & 8'hCC) >> 2) | ((a & 8'h33) << 2);
        return ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
    endfunction

endpackage

// ===== hw/rtl/sle_row_unit.sv =====
// Shared row unit: line minus top row, range test and pattern row address.
module sle_row_unit
    import sle_pkg::*;
(
    input  logic [8:0] i_line,
    input  logic [7:0] i_y,
    input  logic [7:0] i_tile,
    input  logic [7:0] i_flags,
    input  logic       i_tall,
    input  logic       i_table_sel,
    output t_row_res   o_res
);

    logic [9:0] w_diff;
    logic       w_vflip;
    logic [2:0] w_row;
    logic       w_half;

    // One subtract serves both evaluation and fetch; bit 9 is the borrow
    assign w_diff  = {1'b0, i_line} - {2'b00, i_y};
    assign w_vflip = i_flags[FLAG_VFLIP];
    assign w_row   = w_diff[2:0] ^ {3{w_vflip}};
    assign w_half  = w_diff[3] ^ w_vflip;

    // Range test: 0..7 rows, 0..15 in tall mode
    always_comb begin
        o_res.qualify = !w_diff[9] &&
                        (i_tall ? (w_diff[8:4] == 5'd0) : (w_diff[8:3] == 6'd0));
        if (i_tall) begin
            o_res.addr_low = {i_tile[0], i_tile[7:1], w_half, 1'b0, w_row};
        end else begin
            o_res.addr_low = {i_table_sel, i_tile, 1'b0, w_row};
        end
    end

endmodule

// ===== hw/rtl/sprite_line_evaluator.sv =====
// Top level: scanline sprite selection and sprite pattern fetch sequencer.
// Every item takes a start pulse while busy is low; busy then rises for the
// work. Start-line and attribute-entry items keep busy high for one cycle,
// and no new item is taken until busy is low again. A fetch item puts out
// one address pair per cycle, one pair per kept sprite, each registered in
// the fetch state after the execute state, the last flagged by last_of_run;
// a fetch with no kept sprites gives nothing. A pattern-bytes item passes
// through the execute, pattern and emit states and is then put out. This
// order comes from the sequencer and the registered read of the kept
// sprite memory feeding the single row unit. Results appear for exactly
// one cycle on o_result_valid and cannot be held off. Configuration writes
// are always ready and must only be issued while the block is idle.
module sprite_line_evaluator
    import sle_pkg::*;
#(
    parameter int SPRITES_PER_LINE = SPRITES_PER_LINE_DEF,
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic signed [9:0] i_line_number,
    input  logic [5:0]        i_entry_index,
    input  logic [7:0]        i_entry_y,
    input  logic [7:0]        i_entry_tile,
    input  logic [7:0]        i_entry_flags,
    input  logic [2:0]        i_slot_number,
    input  logic [7:0]        i_plane_low_in,
    input  logic [7:0]        i_plane_high_in,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    // results
    output logic              o_result_valid,
    output logic              o_result_kind,
    output logic [12:0]       o_fetch_addr_low,
    output logic [12:0]       o_fetch_addr_high,
    output logic [2:0]        o_slot_out,
    output logic              o_last_of_run,
    output logic [3:0]        o_selected_count,
    output logic              o_zero_on_line,
    output logic              o_overflow_flag,
    output logic [7:0]        o_plane_low_out,
    output logic [7:0]        o_plane_high_out
);

    localparam int IW = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;
    localparam int CW = $clog2(SPRITES_PER_LINE + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_PAT,
        S_PAT_EM
    } t_state;

    t_state         r_state;
    t_kind          r_kind;
    logic [9:0]     r_line_number;
    logic [5:0]     r_entry_index;
    t_entry         r_entry;
    logic [2:0]     r_slot;
    logic [7:0]     r_plane_low;
    logic [7:0]     r_plane_high;

    logic           r_tall;
    logic           r_table_sel;
    logic [8:0]     r_line;
    logic [CW-1:0]  r_count;
    logic           r_zero;
    logic           r_overflow;
    logic [CW-1:0]  r_idx;
    logic [7:0]     r_shift_low  [SPRITES_PER_LINE];
    logic [7:0]     r_shift_high [SPRITES_PER_LINE];

    // kept sprite memory
    t_entry         r_mem [SPRITES_PER_LINE];
    t_entry         r_rd_data;

    t_entry         w_unit_in;
    t_row_res       w_res;
    logic           w_mem_we;
    logic [IW-1:0]  w_rd_addr;
    logic [IW-1:0]  w_slot_idx;
    logic           w_slot_ok;
    logic           w_index_ok;
    logic           w_room;
    logic [CW-1:0]  w_idx_next;
    logic           w_last;
    logic [7:0]     w_lo_fix;
    logic [7:0]     w_hi_fix;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Decode helpers
    assign w_slot_idx = IW'(r_slot);
    assign w_slot_ok  = int'(r_slot) < SPRITES_PER_LINE;
    assign w_index_ok = int'(r_entry_index) < TABLE_ENTRIES;
    assign w_room     = int'(r_count) < SPRITES_PER_LINE;
    assign w_idx_next = r_idx + CW'(1);
    assign w_last     = (w_idx_next == r_count);

    // Row unit operands: the entry under test, or the entry read back
    assign w_unit_in = (r_state == S_EXEC) ? r_entry : r_rd_data;

    sle_row_unit u_row (
        .i_line      (r_line),
        .i_y         (w_unit_in.y),
        .i_tile      (w_unit_in.tile),
        .i_flags     (w_unit_in.flags),
        .i_tall      (r_tall),
        .i_table_sel (r_table_sel),
        .o_res       (w_res)
    );

    // Memory write when an entry is kept
    assign w_mem_we = (r_state == S_EXEC) && (r_kind == KIND_ENTRY) &&
                      w_index_ok && w_res.qualify && w_room;

    // Memory read address
    always_comb begin
        case (r_state)
            S_EXEC:  w_rd_addr = (r_kind == KIND_PATTERN) ? w_slot_idx : IW'(0);
            S_FETCH: w_rd_addr = w_idx_next[IW-1:0];
            default: w_rd_addr = w_slot_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IW-1:0]] <= r_entry;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Optional horizontal flip of the returned bytes
    assign w_lo_fix = r_rd_data.flags[FLAG_HFLIP] ? mirror_bits(r_plane_low)
                                                  : r_plane_low;
    assign w_hi_fix = r_rd_data.flags[FLAG_HFLIP] ? mirror_bits(r_plane_high)
                                                  : r_plane_high;

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tall         <= 1'b0;
            r_table_sel    <= 1'b0;
            r_line         <= 9'd0;
            r_count        <= '0;
            r_zero         <= 1'b0;
            r_overflow     <= 1'b0;
            r_idx          <= '0;
            o_result_valid <= 1'b0;
            for (int i = 0; i < SPRITES_PER_LINE; i++) begin
                r_shift_low[i]  <= 8'd0;
                r_shift_high[i] <= 8'd0;
            end
        end else begin
            o_result_valid <= 1'b0;

            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TALL:      r_tall      <= i_cfg_data[0];
                    CFG_TABLE_SEL: r_table_sel <= i_cfg_data[0];
                    default:       ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind        <= t_kind'(i_kind);
                        r_line_number <= i_line_number;
                        r_entry_index <= i_entry_index;
                        r_entry.y     <= i_entry_y;
                        r_entry.tile  <= i_entry_tile;
                        r_entry.flags <= i_entry_flags;
                        r_slot        <= i_slot_number;
                        r_plane_low   <= i_plane_low_in;
                        r_plane_high  <= i_plane_high_in;
                        r_state       <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_kind)
                        KIND_START: begin
                            if (r_line_number[9]) begin
                                r_line <= PRE_RENDER_LINE;
                            end else begin
                                r_line     <= r_line_number[8:0];
                                r_count    <= '0;
                                r_zero     <= 1'b0;
                                r_overflow <= 1'b0;
                                for (int i = 0; i < SPRITES_PER_LINE; i++) begin
                                    r_shift_low[i]  <= 8'd0;
                                    r_shift_high[i] <= 8'd0;
                                end
                            end
                        end
                        KIND_ENTRY: begin
                            if (w_index_ok && w_res.qualify) begin
                                if (!w_room) begin
                                    r_overflow <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    if (r_entry_index == 6'd0) begin
                                        r_zero <= 1'b1;
                                    end
                                end
                            end
                        end
                        KIND_FETCH: begin
                            r_idx <= '0;
                            if (r_count != '0) begin
                                r_state <= S_FETCH;
                            end
                        end
                        default: begin
                            if (w_slot_ok) begin
                                r_state <= S_PAT;
                            end
                        end
                    endcase
                end
                S_FETCH: begin
                    o_result_valid    <= 1'b1;
                    o_result_kind     <= RES_ADDR;
                    o_fetch_addr_low  <= w_res.addr_low;
                    o_fetch_addr_high <= w_res.addr_low + 13'd8;
                    o_slot_out        <= 3'(r_idx);
                    o_last_of_run     <= w_last;
                    o_selected_count  <= 4'(r_count);
                    o_zero_on_line    <= r_zero;
                    o_overflow_flag   <= r_overflow;
                    o_plane_low_out   <= 8'd0;
                    o_plane_high_out  <= 8'd0;
                    r_idx             <= w_idx_next;
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAT: begin
                    r_shift_low[w_slot_idx]  <= w_lo_fix;
                    r_shift_high[w_slot_idx] <= w_hi_fix;
                    r_state                  <= S_PAT_EM;
                end
                S_PAT_EM: begin
                    o_result_valid    <= 1'b1;
                    o_result_kind     <= RES_PATTERN;
                    o_fetch_addr_low  <= 13'd0;
                    o_fetch_addr_high <= 13'd0;
                    o_slot_out        <= r_slot;
                    o_last_of_run     <= 1'b0;
                    o_selected_count  <= 4'(r_count);
                    o_zero_on_line    <= r_zero;
                    o_overflow_flag   <= r_overflow;
                    o_plane_low_out   <= r_shift_low[w_slot_idx];
                    o_plane_high_out  <= r_shift_high[w_slot_idx];
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sle_checker.sv =====
// Port-level checker for the sprite line evaluator, with its bind.
module sle_checker
    import sle_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic        o_result_kind,
    input logic [12:0] o_fetch_addr_low,
    input logic [12:0] o_fetch_addr_high,
    input logic        o_last_of_run
);

    // An accepted item always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // An address run that is not finished continues in the next cycle
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == RES_ADDR) && !o_last_of_run)
        |=> (o_result_valid && (o_result_kind == RES_ADDR)))
        else $error("fetch run broken before its last item");

    // High plane address is the low one plus a row of eight
    a_addr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == RES_ADDR))
        |-> (o_fetch_addr_high == o_fetch_addr_low + 13'd8))
        else $error("address pair mismatch");

    // Pattern results carry no addresses and no run end
    a_pattern_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == RES_PATTERN))
        |-> (o_fetch_addr_low == 13'd0 && o_fetch_addr_high == 13'd0 &&
             !o_last_of_run))
        else $error("pattern result with address fields set");

endmodule

bind sprite_line_evaluator sle_checker u_sle_checker (.*);

// ===== tb/sv/tb_sprite_line_evaluator.sv =====
// Self-checking testbench for the scanline sprite evaluator: directed table, then random lines.
`timescale 1ns / 100ps

module tb_sprite_line_evaluator;
    import sle_pkg::*;

    localparam int SLOTS        = SPRITES_PER_LINE_DEF;
    localparam int RANDOM_ITEMS = 350;
    localparam int CALM_ITEMS   = 60;      // tail of the run with no idling
    localparam int SETTLE       = 16;      // cycles for a start/entry item to retire
    localparam int TIMEOUT_NS   = 2000000;

    // One command item as driven on the ports
    typedef struct packed {
        t_kind      kind;
        logic [9:0] line;
        logic [5:0] idx;
        logic [7:0] y;
        logic [7:0] tile;
        logic [7:0] flags;
        logic [2:0] slot;
        logic [7:0] lo;
        logic [7:0] hi;
    } sprite_cmd_t;

    // One result as seen on the ports
    typedef struct packed {
        logic        kind;
        logic [12:0] addr_lo;
        logic [12:0] addr_hi;
        logic [2:0]  slot;
        logic        last;
        logic [3:0]  count;
        logic        zero;
        logic        ovf;
        logic [7:0]  plo;
        logic [7:0]  phi;
    } sprite_result_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

    // Directed table row: an item (optionally with a hand-written result) or a register write
    typedef struct packed {
        row_op_t        op;
        sprite_cmd_t    cmd;
        logic [1:0]     reg_index;
        logic [7:0]     reg_data;
        logic           typed;
        sprite_result_t want;
    } plan_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_kind;
    logic signed [9:0] i_line_number;
    logic [5:0]        i_entry_index;
    logic [7:0]        i_entry_y;
    logic [7:0]        i_entry_tile;
    logic [7:0]        i_entry_flags;
    logic [2:0]        i_slot_number;
    logic [7:0]        i_plane_low_in;
    logic [7:0]        i_plane_high_in;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              o_result_valid;
    logic              o_result_kind;
    logic [12:0]       o_fetch_addr_low;
    logic [12:0]       o_fetch_addr_high;
    logic [2:0]        o_slot_out;
    logic              o_last_of_run;
    logic [3:0]        o_selected_count;
    logic              o_zero_on_line;
    logic              o_overflow_flag;
    logic [7:0]        o_plane_low_out;
    logic [7:0]        o_plane_high_out;

    sprite_line_evaluator dut (.*);

    // Predictor state
    logic             tall_mode;
    logic             table_half;
    logic [8:0]       line_now;
    logic [3:0]       kept_n;
    logic             zero_seen;
    logic             over_seen;
    logic [7:0]       slot_y     [SLOTS];
    logic [7:0]       slot_tile  [SLOTS];
    logic [7:0]       slot_flags [SLOTS];
    logic [7:0]       shifter_lo [SLOTS];
    logic [7:0]       shifter_hi [SLOTS];
    logic [SLOTS-1:0] slot_written;   // slots that have held a sprite since reset

    sprite_result_t pending_results[$];
    plan_row_t      plan[$];
    int             errors = 0;
    int             items_sent = 0;
    logic           quiet = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("sprite_line_evaluator regression: fail");
        $finish;
    end

    function automatic logic [7:0] reversed(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) r[b] = v[7 - b];
        return r;
    endfunction

    // Expected results of one accepted item; updates the predictor state
    task automatic predict_sprite_results(input sprite_cmd_t c);
        int             row_gap;
        logic [3:0]     d;
        logic [2:0]     row;
        logic [7:0]     lo;
        logic [7:0]     hi;
        sprite_result_t r;
        case (c.kind)
            KIND_START: begin
                if (c.line[9]) begin
                    // pre-render: latch the dead line, keep everything else
                    line_now = PRE_RENDER_LINE;
                end else begin
                    line_now  = c.line[8:0];
                    kept_n    = '0;
                    zero_seen = 1'b0;
                    over_seen = 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        shifter_lo[i] = '0;
                        shifter_hi[i] = '0;
                    end
                end
            end
            KIND_ENTRY: begin
                row_gap = int'(line_now) - int'(c.y);
                if (row_gap >= 0 && row_gap < (tall_mode ? 16 : 8)) begin
                    if (kept_n >= SLOTS) begin
                        over_seen = 1'b1;
                    end else begin
                        if (c.idx == 6'd0) zero_seen = 1'b1;
                        slot_y[kept_n[2:0]]       = c.y;
                        slot_tile[kept_n[2:0]]    = c.tile;
                        slot_flags[kept_n[2:0]]   = c.flags;
                        slot_written[kept_n[2:0]] = 1'b1;
                        kept_n++;
                    end
                end
            end
            KIND_FETCH: begin
                for (int i = 0; i < int'(kept_n); i++) begin
                    d   = line_now[3:0] - slot_y[i][3:0];
                    row = slot_flags[i][FLAG_VFLIP] ? 3'd7 - d[2:0] : d[2:0];
                    r   = '0;
                    r.kind = RES_ADDR;
                    if (!tall_mode)
                        r.addr_lo = {table_half, slot_tile[i], 1'b0, row};
                    else
                        r.addr_lo = {slot_tile[i][0], slot_tile[i][7:1],
                                     d[3] ^ slot_flags[i][FLAG_VFLIP], 1'b0, row};
                    r.addr_hi = r.addr_lo + 13'd8;
                    r.slot    = 3'(i);
                    r.last    = (i + 1 == int'(kept_n));
                    r.count   = kept_n;
                    r.zero    = zero_seen;
                    r.ovf     = over_seen;
                    pending_results.push_back(r);
                end
            end
            default: begin
                lo = c.lo;
                hi = c.hi;
                if (slot_flags[c.slot][FLAG_HFLIP]) begin
                    lo = reversed(lo);
                    hi = reversed(hi);
                end
                shifter_lo[c.slot] = lo;
                shifter_hi[c.slot] = hi;
                r       = '0;
                r.kind  = RES_PATTERN;
                r.slot  = c.slot;
                r.count = kept_n;
                r.zero  = zero_seen;
                r.ovf   = over_seen;
                r.plo   = lo;
                r.phi   = hi;
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Item builders
    function automatic sprite_cmd_t start_cmd(input logic [9:0] line);
        sprite_cmd_t c;
        c = '0;
        c.kind = KIND_START;
        c.line = line;
        return c;
    endfunction

    function automatic sprite_cmd_t entry_cmd(input logic [5:0] idx, input logic [7:0] y,
                                              input logic [7:0] tile, input logic [7:0] flags);
        sprite_cmd_t c;
        c = '0;
        c.kind  = KIND_ENTRY;
        c.idx   = idx;
        c.y     = y;
        c.tile  = tile;
        c.flags = flags;
        return c;
    endfunction

    function automatic sprite_cmd_t fetch_cmd();
        sprite_cmd_t c;
        c = '0;
        c.kind = KIND_FETCH;
        return c;
    endfunction

    function automatic sprite_cmd_t pattern_cmd(input logic [2:0] slot, input logic [7:0] lo,
                                                input logic [7:0] hi);
        sprite_cmd_t c;
        c = '0;
        c.kind = KIND_PATTERN;
        c.slot = slot;
        c.lo   = lo;
        c.hi   = hi;
        return c;
    endfunction

    // Random item of a given kind; entries aim at rows near the current line
    function automatic sprite_cmd_t random_cmd(input t_kind k);
        int          yy;
        int          s;
        sprite_cmd_t c;
        case (k)
            KIND_START: begin
                case ($urandom_range(0, 9))
                    0:       c = start_cmd(10'h3FF);   // pre-render line
                    1:       c = start_cmd(10'($urandom_range(0, 1023)));
                    2:       c = start_cmd($urandom_range(0, 1) ? 10'd0 : 10'd260);
                    default: c = start_cmd(10'($urandom_range(0, 260)));
                endcase
            end
            KIND_ENTRY: begin
                yy = int'(line_now) - int'($urandom_range(0, 17));
                if (yy < 0 || yy > 255 || $urandom_range(0, 4) == 0)
                    yy = $urandom_range(0, 255);
                c = entry_cmd(($urandom_range(0, 5) == 0) ? 6'd0 : 6'($urandom_range(0, 63)),
                              8'(yy), 8'($urandom), 8'($urandom));
            end
            KIND_FETCH: c = fetch_cmd();
            default: begin
                if (slot_written == '0) begin
                    c = fetch_cmd();
                end else begin
                    // only slots that were ever filled may be read back
                    do s = $urandom_range(0, SLOTS - 1); while (!slot_written[s]);
                    c = pattern_cmd(3'(s), 8'($urandom), 8'($urandom));
                end
            end
        endcase
        return c;
    endfunction

    // Table building
    task automatic plan_item(input sprite_cmd_t c);
        plan_row_t p;
        p = '0;
        p.op  = ROW_ITEM;
        p.cmd = c;
        plan.push_back(p);
    endtask

    task automatic plan_typed(input sprite_cmd_t c, input sprite_result_t want);
        plan_row_t p;
        p = '0;
        p.op    = ROW_ITEM;
        p.cmd   = c;
        p.typed = 1'b1;
        p.want  = want;
        plan.push_back(p);
    endtask

    task automatic plan_reg(input logic [1:0] index, input logic [7:0] data);
        plan_row_t p;
        p = '0;
        p.op        = ROW_REG;
        p.reg_index = index;
        p.reg_data  = data;
        plan.push_back(p);
    endtask

    // Drive one item and wait for it to be taken
    task automatic send_item(input sprite_cmd_t c, input logic typed, input sprite_result_t want);
        int             queued_before;
        sprite_result_t dropped;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_kind          <= c.kind;
        i_line_number   <= c.line;
        i_entry_index   <= c.idx;
        i_entry_y       <= c.y;
        i_entry_tile    <= c.tile;
        i_entry_flags   <= c.flags;
        i_slot_number   <= c.slot;
        i_plane_low_in  <= c.lo;
        i_plane_high_in <= c.hi;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queued_before = pending_results.size();
        predict_sprite_results(c);
        if (typed) begin
            // hand-written result takes the place of the predicted one
            while (pending_results.size() > queued_before) dropped = pending_results.pop_back();
            pending_results.push_back(want);
        end
        items_sent++;
    endtask

    // Stop sending and let every outstanding result come out
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_TALL) tall_mode = data[0];
        else if (index == CFG_TABLE_SEL) table_half = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [12:0] want, input logic [12:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        sprite_result_t want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 13'(want.kind), 13'(o_result_kind));
                check_field("fetch_addr_low", want.addr_lo, o_fetch_addr_low);
                check_field("fetch_addr_high", want.addr_hi, o_fetch_addr_high);
                check_field("slot_out", 13'(want.slot), 13'(o_slot_out));
                check_field("last_of_run", 13'(want.last), 13'(o_last_of_run));
                check_field("selected_count", 13'(want.count), 13'(o_selected_count));
                check_field("zero_on_line", 13'(want.zero), 13'(o_zero_on_line));
                check_field("overflow_flag", 13'(want.ovf), 13'(o_overflow_flag));
                check_field("plane_low_out", 13'(want.plo), 13'(o_plane_low_out));
                check_field("plane_high_out", 13'(want.phi), 13'(o_plane_high_out));
            end
        end
    end

    // Stimulus
    initial begin
        int stop_at;
        int seq;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = '0;
        i_line_number   = '0;
        i_entry_index   = '0;
        i_entry_y       = '0;
        i_entry_tile    = '0;
        i_entry_flags   = '0;
        i_slot_number   = '0;
        i_plane_low_in  = '0;
        i_plane_high_in = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        tall_mode       = 1'b0;
        table_half      = 1'b0;
        line_now        = '0;
        kept_n          = '0;
        zero_seen       = 1'b0;
        over_seen       = 1'b0;
        slot_written    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_y[i]     = '0;
            slot_tile[i]  = '0;
            slot_flags[i] = '0;
            shifter_lo[i] = '0;
            shifter_hi[i] = '0;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset values, one sprite, empty line, overflow, flips, config, pre-render
        plan_item(start_cmd(10'd0));
        plan_item(entry_cmd(6'd0, 8'd0, 8'h00, 8'h00));
        plan_typed(fetch_cmd(),
                   '{RES_ADDR, 13'd0, 13'd8, 3'd0, 1'b1, 4'd1, 1'b1, 1'b0, 8'h00, 8'h00});
        plan_typed(pattern_cmd(3'd0, 8'hFF, 8'h00),
                   '{RES_PATTERN, 13'd0, 13'd0, 3'd0, 1'b0, 4'd1, 1'b1, 1'b0, 8'hFF, 8'h00});
        plan_item(start_cmd(10'd260));
        plan_item(fetch_cmd());                                  // nothing kept: no results
        plan_item(start_cmd(10'd10));
        plan_item(entry_cmd(6'd5, 8'd3, 8'hFF, 8'hC0));
        plan_item(entry_cmd(6'd63, 8'd10, 8'h80, 8'h40));
        plan_item(entry_cmd(6'd1, 8'd11, 8'h11, 8'h00));          // starts below the line
        plan_item(entry_cmd(6'd9, 8'd4, 8'h12, 8'h00));
        plan_item(entry_cmd(6'd20, 8'd5, 8'h34, 8'h80));
        plan_item(entry_cmd(6'd33, 8'd6, 8'h56, 8'h3F));
        plan_item(entry_cmd(6'd41, 8'd7, 8'h78, 8'h40));
        plan_item(entry_cmd(6'd50, 8'd8, 8'h9A, 8'hFF));
        plan_item(entry_cmd(6'd62, 8'd9, 8'hBC, 8'h00));
        plan_item(entry_cmd(6'd0, 8'd10, 8'hDE, 8'h00));          // ninth: overflow, no zero
        plan_item(fetch_cmd());
        plan_item(pattern_cmd(3'd0, 8'h01, 8'h80));
        plan_reg(CFG_TABLE_SEL, 8'hFF);
        plan_item(fetch_cmd());
        plan_reg(CFG_TALL, 8'h01);
        plan_item(fetch_cmd());                                  // tall-mode addresses for the same kept sprites
        plan_item(start_cmd(10'h3FF));                           // pre-render line
        plan_item(entry_cmd(6'd0, 8'd0, 8'h00, 8'h00));
        plan_item(fetch_cmd());
        plan_item(start_cmd(10'd255));
        plan_item(entry_cmd(6'd0, 8'd240, 8'h35, 8'h80));         // bottom row of a tall sprite
        plan_item(fetch_cmd());
        plan_reg(CFG_TALL, 8'hFE);
        plan_reg(CFG_TABLE_SEL, 8'h00);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_REG) begin
                drain_results();
                write_register(plan[i].reg_index, plan[i].reg_data);
            end else begin
                send_item(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end

        // Random lines: start, entries near the line, fetch, pattern bytes; some noise
        stop_at = items_sent + RANDOM_ITEMS;
        seq = 0;
        while (items_sent < stop_at) begin
            quiet = (items_sent >= stop_at - CALM_ITEMS);
            if (!quiet && seq % 6 == 5) begin
                drain_results();
                write_register(CFG_TALL, 8'($urandom));
                write_register(CFG_TABLE_SEL, 8'($urandom));
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_item(random_cmd(t_kind'($urandom_range(0, 3))), 1'b0, '0);
            end else begin
                send_item(random_cmd(KIND_START), 1'b0, '0);
                repeat ($urandom_range(0, 12)) send_item(random_cmd(KIND_ENTRY), 1'b0, '0);
                send_item(random_cmd(KIND_FETCH), 1'b0, '0);
                repeat ($urandom_range(0, 3)) send_item(random_cmd(KIND_PATTERN), 1'b0, '0);
                if ($urandom_range(0, 3) == 0) send_item(random_cmd(KIND_FETCH), 1'b0, '0);
            end
            seq++;
        end

        drain_results();
        if (errors == 0)
            $display("sprite_line_evaluator regression: pass");
        else
            $display("sprite_line_evaluator regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sle_pkg.sv
hw/rtl/sle_row_unit.sv
hw/rtl/sprite_line_evaluator.sv
hw/rtl/sle_checker.sv
tb/sv/tb_sprite_line_evaluator.sv
